// ----- rtl/mhpq_pkg.sv -----
// shared types and constants of the max heap priority queue
package mhpq_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ENTRY_W  = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ----- rtl/mhpq_cell.sv -----
// one cell of the sorted chain: holds one entry and trades it with its neighbors
module mhpq_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mhpq_pkg::cmd_t                     cmd_i,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] left_val_i,
  input  logic                               left_valid_i,
  input  logic                               left_take_i,
  input  logic signed [mhpq_pkg::VALUE_W-1:0] right_val_i,
  input  logic                               right_valid_i,
  output logic signed [mhpq_pkg::VALUE_W-1:0] val_o,
  output logic                               valid_o,
  output logic                               take_o
);
  import mhpq_pkg::*;

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      valid_q, valid_d;
  logic                      take;

  // the new value displaces this entry when it is strictly greater or the cell is free
  assign take = cmd_i.ins && (!valid_q || (cmd_i.value > val_q));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (cmd_i.ins) begin
      valid_d = valid_q || left_valid_i;
      if (take) begin
        val_d = left_take_i ? left_val_i : cmd_i.value;
      end
    end else if (cmd_i.rem) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign take_o  = take;

endmodule

// ----- rtl/mhpq_chain.sv -----
// row of cells kept in descending order, largest entry at the head
module mhpq_chain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mhpq_pkg::cmd_t                      cmd_i,
  output logic signed [mhpq_pkg::VALUE_W-1:0] head_val_o,
  output logic                                head_valid_o,
  output logic [mhpq_pkg::CAPACITY-1:0]       occupied_o
);
  import mhpq_pkg::*;

  logic signed [VALUE_W-1:0] val   [CAPACITY];
  logic                      valid [CAPACITY];
  logic                      take  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val;
    logic                      left_valid;
    logic                      left_take;
    logic signed [VALUE_W-1:0] right_val;
    logic                      right_valid;

    if (i == 0) begin : g_first
      // the head always fills on insert and never takes a shifted entry
      assign left_val   = cmd_i.value;
      assign left_valid = 1'b1;
      assign left_take  = 1'b0;
    end else begin : g_mid_left
      assign left_val   = val[i-1];
      assign left_valid = valid[i-1];
      assign left_take  = take[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val   = val[i];
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_val   = val[i+1];
      assign right_valid = valid[i+1];
    end

    mhpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .left_val_i   (left_val),
      .left_valid_i (left_valid),
      .left_take_i  (left_take),
      .right_val_i  (right_val),
      .right_valid_i(right_valid),
      .val_o        (val[i]),
      .valid_o      (valid[i]),
      .take_o       (take[i])
    );

    assign occupied_o[i] = valid[i];
  end

  assign head_val_o   = val[0];
  assign head_valid_o = valid[0];

endmodule

// ----- rtl/max_heap_priority_queue_top.sv -----
// top level of the max priority queue with stream ports
// result timing: a result is registered and presented in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while the result side takes each result
// every insert or remove finishes in one chain step, all cells shift in parallel
// reset: asynchronous active low, clears the occupancy bits and the count, queue empty
// no clearing pass after reset, the block accepts transactions on the first cycle
module max_heap_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic [0:0]  s_axis_tuser_i,  // [0] operation
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [31:0] max_value, [35:32] entry_count, [39:36] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import mhpq_pkg::*;

  // input side
  logic                      s_fire;
  op_e                       op;
  logic                      full;
  logic                      empty;
  cmd_t                      cmd;

  // chain view
  logic signed [VALUE_W-1:0] head_val;
  logic                      head_valid;
  logic [CAPACITY-1:0]       occupied;

  // entry count
  logic [CNT_W-1:0]          count_q, count_d;

  // result register, parts the two sides of the block
  logic                      out_valid_q, out_valid_d;
  status_e                   out_status_q, out_status_d;
  logic signed [VALUE_W-1:0] out_value_q, out_value_d;
  logic [ENTRY_W-1:0]        out_count_q, out_count_d;

  // a new transaction is taken whenever the result register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign op    = op_e'(s_axis_tuser_i[0]);
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = !head_valid;

  // errors leave the chain untouched
  always_comb begin
    cmd.ins   = s_fire && (op == OP_INSERT) && !full;
    cmd.rem   = s_fire && (op == OP_REMOVE) && !empty;
    cmd.value = s_axis_tdata_i;
  end

  mhpq_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .head_val_o  (head_val),
    .head_valid_o(head_valid),
    .occupied_o  (occupied)
  );

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // build the result of the accepted transaction
  always_comb begin
    out_status_d = ST_OK;
    out_value_d  = '0;
    case (op)
      OP_INSERT: begin
        if (full) begin
          out_status_d = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          // the head cell always holds the maximum
          out_value_d = head_val;
        end
      end
      default: begin
        out_status_d = ST_OK;
      end
    endcase
    // entry count is reported modulo the field width
    out_count_d = ENTRY_W'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the result register, loaded on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_count_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

  // occupancy bits of the chain agree with the count
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occupied) == int'(count_q))
    else $error("chain occupancy and entry count disagree");

  // the head is occupied exactly when the queue holds entries
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid == (count_q != '0))
    else $error("head occupancy and entry count disagree");

  // an insert into a full queue reports the full error
  a_full_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (op == OP_INSERT) && full) |=> (m_axis_tuser_o == ST_FULL))
    else $error("insert into full queue did not report full");

  // a successful remove returns the previous head
  a_remove_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> ((m_axis_tdata_o[31:0] == $past(head_val)) && (m_axis_tuser_o == ST_OK)))
    else $error("remove did not return the head entry");

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the max heap priority queue with stream ports
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  // one command waiting to be offered on the input channel
  typedef struct {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    bit                        drain;  // hold back until every pending result has come out
  } heap_cmd_t;

  // one result as the queue should report it
  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] max_value;
    logic [ENTRY_W-1:0]        entry_count;
  } heap_result_t;

  localparam int unsigned RANDOM_CMDS = 550;
  localparam int unsigned CALM_TAIL   = 80;   // last transactions run with no idling
  localparam int unsigned HOLD_AT     = 150;  // input count that starts the long result hold-off
  localparam int unsigned HOLD_LEN    = 60;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic [0:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  max_heap_priority_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [31:0] value
    .s_axis_tuser_i  (s_axis_tuser_i),   // [0] operation
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [31:0] max_value, [35:32] entry_count, [39:36] zero
    .m_axis_tuser_o  (m_axis_tuser_o)    // [1:0] status
  );

  // 20 ns clock period
  always #10 clk_i = ~clk_i;

  heap_cmd_t    cmd_q[$];       // commands not yet offered
  heap_result_t result_q[$];    // results predicted but not yet seen
  int unsigned  cmd_total    = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  fail_cnt     = 0;
  bit           live         = 1'b0;  // reset seen released at a rising edge
  bit           cmd_taken    = 1'b0;  // input transaction completed at the last rising edge

  // shadow copy of the heap, kept in array heap order
  logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
  int unsigned               heap_cnt = 0;

  // apply one command to the shadow heap and return the result it must produce
  function automatic heap_result_t apply_heap_cmd(op_e op, logic signed [VALUE_W-1:0] v);
    heap_result_t              r;
    int unsigned               pos;
    int unsigned               parent;
    int unsigned               left;
    int unsigned               big;
    logic signed [VALUE_W-1:0] leaf;
    r.status    = ST_OK;
    r.max_value = '0;
    if (op == OP_INSERT) begin
      if (heap_cnt >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // sift up: smaller parents move down, an equal parent stops the walk
        pos      = heap_cnt;
        heap_cnt = heap_cnt + 1;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[parent] >= v) break;
          heap_mem[pos] = heap_mem[parent];
          pos = parent;
        end
        heap_mem[pos] = v;
      end
    end else begin
      if (heap_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.max_value = heap_mem[0];
        heap_cnt    = heap_cnt - 1;
        if (heap_cnt > 0) begin
          // sift the last leaf down toward the larger child, left wins a tie
          leaf = heap_mem[heap_cnt];
          pos  = 0;
          forever begin
            left = 2 * pos + 1;
            if (left >= heap_cnt) break;
            big = left;
            if (left + 1 < heap_cnt && heap_mem[left] < heap_mem[left + 1]) big = left + 1;
            if (!(leaf < heap_mem[big])) break;
            heap_mem[pos] = heap_mem[big];
            pos = big;
          end
          heap_mem[pos] = leaf;
        end
      end
    end
    r.entry_count = ENTRY_W'(heap_cnt);
    return r;
  endfunction

  // random value: extremes, a narrow band that produces ties, or anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(0, 8)) - 32'd4);
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic push_cmd(op_e op, logic signed [VALUE_W-1:0] v, bit drain = 1'b0);
    heap_cmd_t c;
    c.op    = op;
    c.value = v;
    c.drain = drain;
    cmd_q.push_back(c);
    cmd_total = cmd_total + 1;
  endtask

  // stimulus, then wait for the queue to go quiet and report
  initial begin : stimulus_proc
    int unsigned ins_pct;
    // directed part
    push_cmd(OP_REMOVE, 32'sh1234_5678);      // remove from an empty heap
    push_cmd(OP_INSERT, 32'sh8000_0000);      // most negative value
    push_cmd(OP_INSERT, 32'sh7FFF_FFFF);      // most positive value
    push_cmd(OP_REMOVE, 32'sh0);
    push_cmd(OP_REMOVE, -32'sh1);             // removes the only entry left
    push_cmd(OP_REMOVE, 32'sh0);              // empty again
    push_cmd(OP_INSERT, 32'sh5);              // equal values stop the sifts
    push_cmd(OP_INSERT, 32'sh5);
    push_cmd(OP_INSERT, 32'sh5);
    push_cmd(OP_INSERT, -32'sh1);
    push_cmd(OP_INSERT, 32'sh0);
    push_cmd(OP_INSERT, 32'sh7FFF_FFFF);
    push_cmd(OP_INSERT, 32'sh8000_0000);
    push_cmd(OP_INSERT, 32'sh5);              // heap now full
    push_cmd(OP_INSERT, 32'sh1234_5678);      // insert into a full heap
    push_cmd(OP_INSERT, 32'sh7FFF_FFFF);
    repeat (CAPACITY) push_cmd(OP_REMOVE, $signed(32'($urandom)));
    push_cmd(OP_REMOVE, 32'sh0);
    // random part: the insert share changes every 40 commands so the heap
    // swings between empty and full
    ins_pct = 50;
    for (int unsigned i = 0; i < RANDOM_CMDS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          default: ins_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < ins_pct) begin
        push_cmd(OP_INSERT, pick_value(), i == RANDOM_CMDS / 2);
      end else begin
        push_cmd(OP_REMOVE, $signed(32'($urandom)), i == RANDOM_CMDS / 2);
      end
    end

    // reset held from the start, released at a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all commands taken and all results seen
    while (cmd_q.size() != 0 || s_axis_tvalid_i || result_q.size() != 0) @(posedge clk_i);
    // keep running so a stray extra result gets caught
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // input driver: updates at the falling edge, idles in random bursts
  always @(negedge clk_i) begin : drive_proc
    logic        next_valid;
    heap_cmd_t   cur;
    bit          may_idle;
    int unsigned gap_left;
    next_valid = s_axis_tvalid_i;
    // no gaps in the calm tail or around the long result hold-off, so the queue backs up
    may_idle = (accepted_cnt + CALM_TAIL < cmd_total) &&
               !(accepted_cnt >= HOLD_AT - 10 && accepted_cnt < HOLD_AT + HOLD_LEN + 20);
    if (cmd_taken) begin
      cmd_taken  = 1'b0;
      next_valid = 1'b0;
      if (may_idle && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 19);
    end
    if (!next_valid && live) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && result_q.size() != 0)) begin
        cur        = cmd_q.pop_front();
        next_valid = 1'b1;
        s_axis_tdata_i <= cur.value;
        s_axis_tuser_i <= cur.op;
      end
    end
    s_axis_tvalid_i <= next_valid;
  end

  // result side ready: random stalls plus one long hold-off counted here
  always @(negedge clk_i) begin : ready_proc
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    logic        next_ready;
    next_ready = 1'b0;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      next_ready = 1'b1;
      if (accepted_cnt + CALM_TAIL < cmd_total && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 19);
    end
    m_axis_tready_i <= next_ready;
  end

  // monitor: samples both channels at the rising edge, predicts and checks
  always @(posedge clk_i) begin : monitor_proc
    heap_result_t want;
    live = rst_ni;
    if (rst_ni) begin
      // input transaction: run the shadow heap and queue what must come out
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        result_q.push_back(apply_heap_cmd(op_e'(s_axis_tuser_i[0]), s_axis_tdata_i));
        accepted_cnt = accepted_cnt + 1;
        cmd_taken    = 1'b1;
      end
      // result transaction: compare with the oldest prediction
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t ns: result with none expected, status %0d data %h",
                   $time, m_axis_tuser_o, m_axis_tdata_o);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = result_q.pop_front();
          if (m_axis_tuser_o !== want.status) begin
            $display("%0t ns: status expected %0d actual %0d",
                     $time, want.status, m_axis_tuser_o);
            fail_cnt = fail_cnt + 1;
          end
          if (m_axis_tdata_o[31:0] !== want.max_value) begin
            $display("%0t ns: max_value expected %0d actual %0d",
                     $time, want.max_value, $signed(m_axis_tdata_o[31:0]));
            fail_cnt = fail_cnt + 1;
          end
          if (m_axis_tdata_o[35:32] !== want.entry_count) begin
            $display("%0t ns: entry_count expected %0d actual %0d",
                     $time, want.entry_count, m_axis_tdata_o[35:32]);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

// ----- files.f -----
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/mhpq_chain.sv
rtl/max_heap_priority_queue_top.sv
tb/testbench.sv
